// ===== hw/rtl/resize_scale_factor_calc_unit_assert.svh =====
// Assertion macros used by the resize step calculator RTL.
`ifndef RESIZE_SCALE_FACTOR_CALC_UNIT_ASSERT_SVH
`define RESIZE_SCALE_FACTOR_CALC_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define RSF_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rsf assertion failed");

// Next-cycle implication, disabled while in reset.
`define RSF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rsf assertion failed");

`endif

// ===== hw/rtl/rsf_pkg.sv =====
// Shared types and constants of the resize step calculator.
package rsf_pkg;

  localparam int SIZE_IN_W  = 12;
  localparam int SIZE_OUT_W = 16;
  localparam int WORD_W     = 16;
  localparam int FRAC_W     = 12;
  localparam int DIV_W      = 24;

  localparam logic [2:0]        FRAC_LOW_MASK = 3'h7;
  localparam logic [FRAC_W:0]   FRAC_GRAIN    = 13'd8;
  localparam logic [WORD_W-1:0] PASSBAND_BASE = 16'd64;
  localparam logic [WORD_W-1:0] PASSBAND_MAX  = 16'hFFFF;
  localparam logic [11:0]       MANT_LIMIT    = 12'd16;
  // 64 * 4096, the passband numerator for a factor of one
  localparam logic [DIV_W-1:0]  PB_NUM_BASE   = 24'd262144;

  // Factor on the passband numerator, as a left shift
  typedef enum logic [1:0] {
    K_ONE  = 2'd0,
    K_TWO  = 2'd1,
    K_FOUR = 2'd2
  } k_shift_t;

  // Item fields carried alongside the divider stages
  typedef struct packed {
    logic [SIZE_IN_W-1:0]  size_in;
    logic [SIZE_OUT_W-1:0] dst_size;
    logic                  zoom;
    logic                  vertical;
    logic                  force_pb;
    logic [WORD_W-1:0]     scale;
  } side_t;

  typedef struct packed {
    logic              vertical;
    logic [WORD_W-1:0] passband;
    logic [WORD_W-1:0] clip_size;
    logic [WORD_W-1:0] scale_word;
  } out_item_t;

endpackage

// ===== hw/rtl/rsf_div_pipe.sv =====
// Pipelined restoring divider, one quotient bit per stage, with side data.
module rsf_div_pipe (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic [rsf_pkg::DIV_W-1:0]  in_num,
  input  logic [rsf_pkg::DIV_W-1:0]  in_den,
  input  rsf_pkg::side_t             in_side,
  output logic                       out_valid,
  output logic [rsf_pkg::DIV_W-1:0]  out_quo,
  output rsf_pkg::side_t             out_side
);

  localparam int W = rsf_pkg::DIV_W;

  logic         v_r    [W];
  logic [W-1:0] rem_r  [W];
  logic [W-1:0] num_r  [W];
  logic [W-1:0] quo_r  [W];
  logic [W-1:0] den_r  [W];
  rsf_pkg::side_t side_r [W];

  for (genvar s = 0; s < W; s++) begin : g_stage
    logic           v_p;
    logic [W-1:0]   rem_p;
    logic [W-1:0]   num_p;
    logic [W-1:0]   quo_p;
    logic [W-1:0]   den_p;
    rsf_pkg::side_t side_p;
    logic [W:0]     trial;
    logic           ge;
    logic [W-1:0]   rem_nxt;
    logic [W-1:0]   num_nxt;
    logic [W-1:0]   quo_nxt;

    if (s == 0) begin : g_first
      assign v_p    = in_valid;
      assign rem_p  = '0;
      assign num_p  = in_num;
      assign quo_p  = '0;
      assign den_p  = in_den;
      assign side_p = in_side;
    end else begin : g_next
      assign v_p    = v_r[s-1];
      assign rem_p  = rem_r[s-1];
      assign num_p  = num_r[s-1];
      assign quo_p  = quo_r[s-1];
      assign den_p  = den_r[s-1];
      assign side_p = side_r[s-1];
    end

    // shift in the next dividend bit, subtract the divisor when it fits
    assign trial   = {rem_p, num_p[W-1]};
    assign ge      = trial >= {1'b0, den_p};
    assign rem_nxt = ge ? W'(trial - {1'b0, den_p}) : trial[W-1:0];
    assign num_nxt = {num_p[W-2:0], 1'b0};
    assign quo_nxt = {quo_p[W-2:0], ge};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else if (en) begin
        v_r[s] <= v_p;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s]  <= rem_nxt;
        num_r[s]  <= num_nxt;
        quo_r[s]  <= quo_nxt;
        den_r[s]  <= den_p;
        side_r[s] <= side_p;
      end
    end
  end

  assign out_valid = v_r[W-1];
  assign out_quo   = quo_r[W-1];
  assign out_side  = side_r[W-1];

endmodule

// ===== hw/rtl/resize_scale_factor_calc_unit.sv =====
// Resize step calculator: one axis's sizes in, 4.12 step, clip size and passband out.
//
// Input channel in_*: one word per axis, carrying size_in, dst_size and the zoom
// flag in in_tdata and the axis marker in in_tuser. Output channel out_*: one
// word per input word, in order, carrying scale_word, clip_size and passband in
// out_tdata and the axis marker in out_tuser.
//
// From acceptance to out_tvalid a word passes an input register, a
// 24-stage step divider, a rounding stage, a 24-stage passband divider and the
// output register. Each divider resolves one quotient bit per stage, so a new
// word is accepted, one word per cycle, whenever the skid register is empty.
//
// Reset clears all valid bits; payload registers are not reset. When the
// receiver stalls, the output register holds its word and a skid register
// catches the one word still leaving the pipeline; while the skid register is
// full, in_tready is low and every stage holds, so nothing is lost or repeated.
// in_tready depends only on registered state.
`include "resize_scale_factor_calc_unit_assert.svh"

module resize_scale_factor_calc_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // size_in[11:0], dst_size[27:12], zoom[28], zero pad
  input  logic        in_tuser,   // vertical[0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // scale_word[15:0], clip_size[31:16], passband[47:32]
  output logic        out_tuser   // vertical_out[0]
);

  localparam int IW = rsf_pkg::SIZE_IN_W;
  localparam int OW = rsf_pkg::SIZE_OUT_W;
  localparam int DW = rsf_pkg::DIV_W;
  localparam int FW = rsf_pkg::FRAC_W;
  localparam int MW = DW - FW;

  logic en;
  logic sk_v_r;

  // input register
  logic          s0_v_r;
  logic [IW-1:0] s0_size_in_r;
  logic [OW-1:0] s0_dst_size_r;
  logic          s0_zoom_r;
  logic          s0_vert_r;

  assign en        = !sk_v_r;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
    end else if (en) begin
      s0_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_size_in_r  <= in_tdata[11:0];
      s0_dst_size_r <= in_tdata[27:12];
      s0_zoom_r     <= in_tdata[28];
      s0_vert_r     <= in_tuser;
    end
  end

  // step = 4096 * (size_in - 1) / (dst_size + 1)
  logic [IW-1:0]   span;
  logic [DW-1:0]   d1_num;
  logic [DW-1:0]   d1_den;
  rsf_pkg::side_t  d1_side_in;
  logic            d1_v;
  logic [DW-1:0]   d1_quo;
  rsf_pkg::side_t  d1_side;

  assign span   = (s0_size_in_r != '0) ? (s0_size_in_r - IW'(1)) : '0;
  assign d1_num = {span, {FW{1'b0}}};
  assign d1_den = DW'({1'b0, s0_dst_size_r} + (OW+1)'(1));

  always_comb begin
    d1_side_in          = '0;
    d1_side_in.size_in  = s0_size_in_r;
    d1_side_in.dst_size = s0_dst_size_r;
    d1_side_in.zoom     = s0_zoom_r;
    d1_side_in.vertical = s0_vert_r;
  end

  rsf_div_pipe u_step_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (s0_v_r),
    .in_num    (d1_num),
    .in_den    (d1_den),
    .in_side   (d1_side_in),
    .out_valid (d1_v),
    .out_quo   (d1_quo),
    .out_side  (d1_side)
  );

  // round the fraction to a multiple of eight and pick the passband factor
  logic [MW-1:0]     mant;
  logic [FW-1:0]     frac;
  logic [FW-1:0]     frac_fl;
  logic [FW:0]       frac_rnd;
  logic [DW-1:0]     step_nxt;
  rsf_pkg::k_shift_t ksh_nxt;
  rsf_pkg::side_t    rd_side_nxt;

  always_comb begin
    mant    = d1_quo[DW-1:FW];
    frac    = d1_quo[FW-1:0];
    frac_fl = {frac[FW-1:3], 3'b000};
    if ((frac[2:0] & rsf_pkg::FRAC_LOW_MASK) != 3'b000) begin
      if (d1_side.dst_size > OW'(d1_side.size_in)) begin
        // enlarging: go one grain of eight below the rounded-down value, floor at zero
        frac_rnd = ({1'b0, frac_fl} >= rsf_pkg::FRAC_GRAIN) ?
                   ({1'b0, frac_fl} - rsf_pkg::FRAC_GRAIN) : '0;
      end else begin
        frac_rnd = {1'b0, frac_fl} + rsf_pkg::FRAC_GRAIN;
      end
    end else begin
      frac_rnd = {1'b0, frac};
    end
    if (d1_side.dst_size == OW'(d1_side.size_in)) begin
      mant     = '0;
      frac_rnd = '0;
    end
    // a fraction rounded up to a whole unit carries into the mantissa here
    step_nxt = {mant, {FW{1'b0}}} + DW'(frac_rnd);
    if (mant >= MW'(8) && mant < rsf_pkg::MANT_LIMIT) begin
      ksh_nxt = rsf_pkg::K_FOUR;
    end else if (mant >= MW'(4) && mant < MW'(8)) begin
      ksh_nxt = rsf_pkg::K_TWO;
    end else begin
      ksh_nxt = rsf_pkg::K_ONE;
    end
    rd_side_nxt          = d1_side;
    rd_side_nxt.force_pb = d1_side.zoom || (step_nxt == '0);
    rd_side_nxt.scale    = step_nxt[rsf_pkg::WORD_W-1:0];
  end

  logic              rd_v_r;
  logic [DW-1:0]     rd_step_r;
  rsf_pkg::k_shift_t rd_ksh_r;
  rsf_pkg::side_t    rd_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_v_r <= 1'b0;
    end else if (en) begin
      rd_v_r <= d1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rd_step_r <= step_nxt;
      rd_ksh_r  <= ksh_nxt;
      rd_side_r <= rd_side_nxt;
    end
  end

  // passband = 64 * 4096 * k / step
  logic [DW-1:0]  d2_num;
  logic           d2_v;
  logic [DW-1:0]  d2_quo;
  rsf_pkg::side_t d2_side;

  assign d2_num = rsf_pkg::PB_NUM_BASE << rd_ksh_r;

  rsf_div_pipe u_pb_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (rd_v_r),
    .in_num    (d2_num),
    .in_den    (rd_step_r),
    .in_side   (rd_side_r),
    .out_valid (d2_v),
    .out_quo   (d2_quo),
    .out_side  (d2_side)
  );

  rsf_pkg::out_item_t fin;

  always_comb begin
    fin.vertical   = d2_side.vertical;
    fin.clip_size  = d2_side.dst_size;
    fin.scale_word = d2_side.scale;
    if (d2_side.force_pb) begin
      fin.passband = rsf_pkg::PASSBAND_BASE;
    end else if (d2_quo > DW'(rsf_pkg::PASSBAND_MAX)) begin
      fin.passband = rsf_pkg::PASSBAND_MAX;
    end else begin
      fin.passband = d2_quo[rsf_pkg::WORD_W-1:0];
    end
  end

  // output register and skid register
  logic               out_v_r;
  rsf_pkg::out_item_t out_d_r;
  rsf_pkg::out_item_t sk_d_r;
  logic               take;

  assign take = out_v_r && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
      sk_v_r  <= 1'b0;
    end else if (en) begin
      if (d2_v) begin
        if (!out_v_r || take) begin
          out_v_r <= 1'b1;
          out_d_r <= fin;
        end else begin
          // receiver stalled: park the word leaving the pipeline
          sk_v_r <= 1'b1;
          sk_d_r <= fin;
        end
      end else if (take) begin
        out_v_r <= 1'b0;
      end
    end else if (take) begin
      out_d_r <= sk_d_r;
      out_v_r <= 1'b1;
      sk_v_r  <= 1'b0;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {out_d_r.passband, out_d_r.clip_size, out_d_r.scale_word};
  assign out_tuser  = out_d_r.vertical;

  `RSF_ASSERT_NOW(a_skid_behind_out, sk_v_r, out_v_r)
  `RSF_ASSERT_NEXT(a_skid_holds_on_stall, sk_v_r && !out_tready, sk_v_r)
  `RSF_ASSERT_NOW(a_skid_fills_on_stall, $rose(sk_v_r), $past(out_v_r && !out_tready))

endmodule
